[rtl/assert_macros.svh]
// Assertion macros shared by the day count to calendar date RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define DCD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define DCD_ASSERT(lbl, clk, rst_n, prop)
`define DCD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/dcd_pkg.sv]
// Constants and helper functions for the day count to calendar date unit.
// Depends on nothing; used by the interfaces and the top level.
package dcd_pkg;

    localparam int YEAR_W  = 13;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int Q400_W  = 7;
    localparam int DOY_W   = 9;
    localparam int WIDE_W  = 25;
    localparam int NUM_ST  = 7;

    localparam int DAYS_400Y = 400 * 365 + 97;
    localparam int DAYS_100Y = 100 * 365 + 24;
    localparam int DAYS_4Y   = 4 * 365 + 1;
    localparam int DAYS_YEAR = 365;
    localparam int DAYS_LEAP = 366;

    // floor(2^32 / DAYS_400Y) and floor(2^24 / DAYS_4Y).
    localparam int REC_400Y = 29398;
    localparam int REC_4Y   = 11483;

    localparam int EPOCH_YEAR    = 2000;
    localparam int EPOCH_WEEKDAY = 6;
    localparam int WEEKDAY_MAX   = 6;
    localparam int MONTH_FEB     = 2;
    localparam int FEB_LEAP_DAYS = 29;

    // Remainder by 7 through octal digit folding, since 8 is 1 modulo 7.
    function automatic logic [WDAY_W-1:0] mod7(input logic [26:0] x);
        logic [5:0] s;
        logic [3:0] t;
        logic [3:0] u;
        s = '0;
        for (int i = 0; i < 9; i++) begin
            s = s + 6'(x[3*i +: 3]);
        end
        t = 4'(s[5:3]) + 4'(s[2:0]);
        u = 4'(t[3]) + 4'(t[2:0]);
        if (u >= 4'd7) begin
            u = u - 4'd7;
        end
        return u[2:0];
    endfunction

    // Day of year on which month index m (0 is January) begins.
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m, input logic leap);
        logic [DOY_W-1:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && m >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

[rtl/dcd_if.sv]
// Valid/ready channels for day counts in and calendar dates out.
// Depends on dcd_pkg for the field widths.
interface dcd_in_if #(
    parameter int DAY_BITS = 20
) ();
    logic                valid;
    logic                ready;
    logic [DAY_BITS-1:0] day_index;

    modport source (output valid, output day_index, input ready);
    modport sink   (input valid, input day_index, output ready);
endinterface

interface dcd_out_if ();
    logic                        valid;
    logic                        ready;
    logic [dcd_pkg::YEAR_W-1:0]  year;
    logic [dcd_pkg::MONTH_W-1:0] month;
    logic [dcd_pkg::DOM_W-1:0]   day_of_month;
    logic [dcd_pkg::WDAY_W-1:0]  weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output weekday, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input weekday, output ready);
endinterface

[rtl/day_count_to_calendar_date_unit.sv]
// Converts days since 2000-01-01 into Gregorian year, month, day and weekday.
// Throughput is one item per cycle; each pipeline stage holds its item on a
// stall and takes a new one whenever it or a later stage has room.
// Synchronous active-low reset empties the pipeline; payload is not reset.
// Depends on dcd_pkg, dcd_if and assert_macros.svh.
`include "assert_macros.svh"

module day_count_to_calendar_date_unit #(
    parameter int DAY_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcd_in_if.sink    i_req,
    dcd_out_if.source o_rsp
);

    localparam int NS = dcd_pkg::NUM_ST;

    logic [NS-1:0] r_v;
    logic [NS-1:0] stg_rdy;

    // A stage can load when it is empty or its item moves on this cycle.
    always_comb begin
        stg_rdy[NS-1] = !r_v[NS-1] || o_rsp.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_v[k] || stg_rdy[k+1];
        end
    end

    assign i_req.ready = stg_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stg_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: estimate of the 400-year count (low by at most one), weekday.
    logic [DAY_BITS-1:0]             r1_d;
    logic [dcd_pkg::Q400_W-1:0]      r1_q;
    logic [dcd_pkg::WDAY_W-1:0]      r1_wd;
    logic [39:0]                     c1_prod;

    assign c1_prod = 40'(i_req.day_index) * 40'(dcd_pkg::REC_400Y);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r1_d  <= i_req.day_index;
            r1_q  <= c1_prod[32 +: dcd_pkg::Q400_W];
            r1_wd <= dcd_pkg::mod7(27'(i_req.day_index) + 27'(dcd_pkg::EPOCH_WEEKDAY));
        end
    end

    // Stage 2: remainder within the 400-year cycle with one correction step.
    logic [dcd_pkg::WIDE_W-1:0] c2_rest;
    logic [dcd_pkg::Q400_W-1:0] r2_q;
    logic [17:0]                r2_r;
    logic [dcd_pkg::WDAY_W-1:0] r2_wd;

    assign c2_rest = dcd_pkg::WIDE_W'(r1_d)
                   - dcd_pkg::WIDE_W'(dcd_pkg::WIDE_W'(r1_q) *
                                      dcd_pkg::WIDE_W'(dcd_pkg::DAYS_400Y));

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            if (c2_rest >= dcd_pkg::WIDE_W'(dcd_pkg::DAYS_400Y)) begin
                r2_q <= r1_q + 7'd1;
                r2_r <= 18'(c2_rest - dcd_pkg::WIDE_W'(dcd_pkg::DAYS_400Y));
            end else begin
                r2_q <= r1_q;
                r2_r <= 18'(c2_rest);
            end
            r2_wd <= r1_wd;
        end
    end

    // Stage 3: century within the cycle; only the first one opens with a leap year.
    logic [16:0]                c3_sub;
    logic [1:0]                 c3_cen;
    logic [15:0]                c3_rc;
    logic [15:0]                r3_rc;
    logic                       r3_cen0;
    logic [dcd_pkg::YEAR_W-1:0] r3_year;
    logic [dcd_pkg::WDAY_W-1:0] r3_wd;

    always_comb begin
        c3_sub = 17'(r2_r) - 17'(dcd_pkg::DAYS_100Y + 1);
        if (r2_r < 18'(dcd_pkg::DAYS_100Y + 1)) begin
            c3_cen = 2'd0;
            c3_rc  = 16'(r2_r);
        end else if (c3_sub >= 17'(2 * dcd_pkg::DAYS_100Y)) begin
            c3_cen = 2'd3;
            c3_rc  = 16'(c3_sub - 17'(2 * dcd_pkg::DAYS_100Y));
        end else if (c3_sub >= 17'(dcd_pkg::DAYS_100Y)) begin
            c3_cen = 2'd2;
            c3_rc  = 16'(c3_sub - 17'(dcd_pkg::DAYS_100Y));
        end else begin
            c3_cen = 2'd1;
            c3_rc  = 16'(c3_sub);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r3_rc   <= c3_rc;
            r3_cen0 <= (c3_cen == 2'd0);
            r3_year <= 13'(dcd_pkg::EPOCH_YEAR)
                     + 13'(16'(r2_q) * 16'd400)
                     + 13'(9'(c3_cen) * 9'd100);
            r3_wd   <= r2_wd;
        end
    end

    // Stage 4: estimate of the 4-year block. In a later century the first block
    // is one day short, so the count is shifted up by one to line blocks up.
    logic [15:0]                c4_t;
    logic [31:0]                c4_prod;
    logic [15:0]                r4_t;
    logic [4:0]                 r4_q;
    logic                       r4_cen0;
    logic [dcd_pkg::YEAR_W-1:0] r4_year;
    logic [dcd_pkg::WDAY_W-1:0] r4_wd;

    assign c4_t    = r3_cen0 ? r3_rc : r3_rc + 16'd1;
    assign c4_prod = 32'(c4_t) * 32'(dcd_pkg::REC_4Y);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r4_t    <= c4_t;
            r4_q    <= c4_prod[28:24];
            r4_cen0 <= r3_cen0;
            r4_year <= r3_year;
            r4_wd   <= r3_wd;
        end
    end

    // Stage 5: correct the block count and find the day within the block.
    logic [15:0]                c5_rest;
    logic [4:0]                 c5_q;
    logic [10:0]                c5_rem;
    logic                       c5_first_leap;
    logic [10:0]                r5_rem;
    logic                       r5_first_leap;
    logic [dcd_pkg::YEAR_W-1:0] r5_year;
    logic [dcd_pkg::WDAY_W-1:0] r5_wd;

    always_comb begin
        c5_rest = r4_t - 16'(16'(r4_q) * 16'(dcd_pkg::DAYS_4Y));
        if (c5_rest >= 16'(dcd_pkg::DAYS_4Y)) begin
            c5_q   = r4_q + 5'd1;
            c5_rem = 11'(c5_rest - 16'(dcd_pkg::DAYS_4Y));
        end else begin
            c5_q   = r4_q;
            c5_rem = 11'(c5_rest);
        end
        c5_first_leap = 1'b1;
        // The short first block of a later century: undo the shift by one.
        if (!r4_cen0 && c5_q == 5'd0) begin
            c5_rem        = 11'(r4_t) - 11'd1;
            c5_first_leap = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[4]) begin
            r5_rem        <= c5_rem;
            r5_first_leap <= c5_first_leap;
            r5_year       <= r4_year + 13'({c5_q, 2'b00});
            r5_wd         <= r4_wd;
        end
    end

    // Stage 6: year within the block and day of year.
    logic [1:0]                 c6_yy;
    logic [dcd_pkg::DOY_W-1:0]  c6_doy;
    logic                       c6_leap;
    logic [dcd_pkg::DOY_W-1:0]  r6_doy;
    logic                       r6_leap;
    logic [dcd_pkg::YEAR_W-1:0] r6_year;
    logic [dcd_pkg::WDAY_W-1:0] r6_wd;

    localparam int L1 = dcd_pkg::DAYS_LEAP;
    localparam int L2 = dcd_pkg::DAYS_LEAP + dcd_pkg::DAYS_YEAR;
    localparam int L3 = dcd_pkg::DAYS_LEAP + 2 * dcd_pkg::DAYS_YEAR;
    localparam int N1 = dcd_pkg::DAYS_YEAR;
    localparam int N2 = 2 * dcd_pkg::DAYS_YEAR;
    localparam int N3 = 3 * dcd_pkg::DAYS_YEAR;

    always_comb begin
        c6_leap = 1'b0;
        if (r5_first_leap) begin
            if (r5_rem < 11'(L1)) begin
                c6_yy   = 2'd0;
                c6_doy  = 9'(r5_rem);
                c6_leap = 1'b1;
            end else if (r5_rem < 11'(L2)) begin
                c6_yy  = 2'd1;
                c6_doy = 9'(r5_rem - 11'(L1));
            end else if (r5_rem < 11'(L3)) begin
                c6_yy  = 2'd2;
                c6_doy = 9'(r5_rem - 11'(L2));
            end else begin
                c6_yy  = 2'd3;
                c6_doy = 9'(r5_rem - 11'(L3));
            end
        end else begin
            if (r5_rem < 11'(N1)) begin
                c6_yy  = 2'd0;
                c6_doy = 9'(r5_rem);
            end else if (r5_rem < 11'(N2)) begin
                c6_yy  = 2'd1;
                c6_doy = 9'(r5_rem - 11'(N1));
            end else if (r5_rem < 11'(N3)) begin
                c6_yy  = 2'd2;
                c6_doy = 9'(r5_rem - 11'(N2));
            end else begin
                c6_yy  = 2'd3;
                c6_doy = 9'(r5_rem - 11'(N3));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[5]) begin
            r6_doy  <= c6_doy;
            r6_leap <= c6_leap;
            r6_year <= r5_year + 13'(c6_yy);
            r6_wd   <= r5_wd;
        end
    end

    // Stage 7: month by comparing against the month start days, then day of month.
    logic [3:0]                  c7_m;
    logic [dcd_pkg::DOY_W-1:0]   c7_start;
    logic [dcd_pkg::YEAR_W-1:0]  r7_year;
    logic [dcd_pkg::MONTH_W-1:0] r7_month;
    logic [dcd_pkg::DOM_W-1:0]   r7_dom;
    logic [dcd_pkg::WDAY_W-1:0]  r7_wd;

    always_comb begin
        c7_m = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r6_doy >= dcd_pkg::month_start(4'(k), r6_leap)) begin
                c7_m = 4'(k);
            end
        end
        c7_start = dcd_pkg::month_start(c7_m, r6_leap);
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[6]) begin
            r7_year  <= r6_year;
            r7_month <= c7_m + 4'd1;
            r7_dom   <= 5'(r6_doy - c7_start + 9'd1);
            r7_wd    <= r6_wd;
        end
    end

    assign o_rsp.valid        = r_v[NS-1];
    assign o_rsp.year         = r7_year;
    assign o_rsp.month        = r7_month;
    assign o_rsp.day_of_month = r7_dom;
    assign o_rsp.weekday      = r7_wd;

    `DCD_ASSERT(a_accept_enters, i_clk, i_rst_n, i_req.valid && i_req.ready |=> r_v[0])
    `DCD_ASSERT(a_cycle_rem, i_clk, i_rst_n, r_v[1] |-> r2_r < 18'(dcd_pkg::DAYS_400Y))
    `DCD_ASSERT(a_month_range, i_clk, i_rst_n,
                o_rsp.valid |-> (o_rsp.month >= 4'd1 && o_rsp.month <= 4'd12))
    `DCD_ASSERT(a_feb_len, i_clk, i_rst_n,
                o_rsp.valid && o_rsp.month == 4'(dcd_pkg::MONTH_FEB)
                |-> o_rsp.day_of_month <= 5'(dcd_pkg::FEB_LEAP_DAYS))
    `DCD_ASSERT_NEVER(a_dom_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.day_of_month == 5'd0)
    `DCD_ASSERT_NEVER(a_wday_range, i_clk, i_rst_n,
                      o_rsp.valid && o_rsp.weekday > 3'(dcd_pkg::WEEKDAY_MAX))

endmodule
